[sv/clle_pkg.sv]
// Shared types and codes for the cursor linked list engine.
`default_nettype none
package clle_pkg;

  typedef enum logic [1:0] {
    K_INSERT  = 2'd0,
    K_DELETE  = 2'd1,
    K_FIND    = 2'd2,
    K_REPLACE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_MISSING  = 2'd1,
    ST_FULL     = 2'd2,
    ST_POSITION = 2'd3
  } status_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [3:0]         position;
    logic signed [15:0] value;
    logic signed [15:0] new_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [2:0] slot;
    logic [2:0] head;
  } out_item_t;

endpackage
`default_nettype wire

[sv/cursor_linked_list_engine.sv]
// Top level: linked list in a slot store with a free chain, one request at a time.
//
// Requests enter on in_item when start is high and busy is low. Kinds are
// insert at a 1-based position, delete, find and replace of the first node
// holding a value. Every request gives exactly one item on out_item, marked by
// a one-cycle out_valid strobe; the receiver cannot stall it.
// A small sequencer walks the list one node per cycle through the two slot
// memories (value and link), whose registered read port sets the pace.
// Rejected requests (full, bad position, empty list) are answered straight from
// idle. Find and replace walk the list until a match or its end; delete adds a
// step that returns the slot to the free chain. Insert takes a free slot, then
// walks to the predecessor and links it in, unless p = 1 or the list is empty.
// busy is high while a request is in progress and is low again when its strobe is high.
// A new request may be accepted in the cycle its predecessor's strobe is high.
// Reset (synchronous, rst_n low) empties the list and chains every slot from
// 1 upward into the free chain at once; link entries read their reset value
// until first written. Slot 0 is the null cursor and never holds a node.
`default_nettype none
module cursor_linked_list_engine import clle_pkg::*; #(
  parameter int SLOTS      = 8,
  parameter int VALUE_BITS = 16
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      start,
  input  wire in_item_t  in_item,
  output logic           busy,
  output logic           out_valid,
  output out_item_t      out_item
);

  localparam int SW = $clog2(SLOTS);
  localparam int LW = $clog2(SLOTS + 1);
  localparam int CW = (LW + 1 > 4) ? LW + 1 : 4;

  typedef logic [SW-1:0] slot_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_L_CMP,
    S_D_FREE,
    S_I_FREE,
    S_I_WALK,
    S_I_LINK
  } state_t;

  state_t                state_r, state_nxt;
  slot_t                 head_r, head_nxt;
  slot_t                 free_r, free_nxt;
  logic [LW-1:0]         len_r, len_nxt;
  slot_t                 cur_r, cur_nxt;    // lookup node, or new slot on insert
  slot_t                 prev_r, prev_nxt;  // predecessor, or walk node on insert
  logic [LW-1:0]         cnt_r, cnt_nxt;
  logic [3:0]            hops_r, hops_nxt;
  kind_t                 kind_r, kind_nxt;
  logic [3:0]            pos_r, pos_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [VALUE_BITS-1:0] nval_r, nval_nxt;
  logic [SLOTS-1:0]      link_vld_r;
  slot_t                 rd_addr_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r, out_item_nxt;

  slot_t                 rd_addr;
  logic                  val_we, lnk_we;
  slot_t                 val_waddr, lnk_waddr;
  logic [VALUE_BITS-1:0] val_wdata, val_q;
  slot_t                 lnk_wdata, lnk_q;
  slot_t                 lnk_dflt, link_eff;
  logic [VALUE_BITS-1:0] in_key, in_nkey;

  assign in_key  = VALUE_BITS'($unsigned(in_item.value));
  assign in_nkey = VALUE_BITS'($unsigned(in_item.new_value));

  clle_ram #(.WIDTH(VALUE_BITS), .DEPTH(SLOTS)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (rd_addr),
    .rdata (val_q)
  );

  clle_ram #(.WIDTH(SW), .DEPTH(SLOTS)) u_lnk_ram (
    .clk   (clk),
    .we    (lnk_we),
    .waddr (lnk_waddr),
    .wdata (lnk_wdata),
    .raddr (rd_addr),
    .rdata (lnk_q)
  );

  // Unwritten link entries read as their reset chain.
  assign lnk_dflt = (rd_addr_r == SW'(SLOTS - 1)) ? '0 : rd_addr_r + 1'b1;
  assign link_eff = link_vld_r[rd_addr_r] ? lnk_q : lnk_dflt;

  always_comb begin
    state_nxt     = state_r;
    head_nxt      = head_r;
    free_nxt      = free_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    cnt_nxt       = cnt_r;
    hops_nxt      = hops_r;
    kind_nxt      = kind_r;
    pos_nxt       = pos_r;
    key_nxt       = key_r;
    nval_nxt      = nval_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    rd_addr       = '0;
    val_we        = 1'b0;
    val_waddr     = cur_r;
    val_wdata     = key_r;
    lnk_we        = 1'b0;
    lnk_waddr     = cur_r;
    lnk_wdata     = head_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt = kind_t'(in_item.kind);
          pos_nxt  = in_item.position;
          key_nxt  = in_key;
          nval_nxt = in_nkey;
          if (in_item.kind == K_INSERT) begin
            if (free_r == '0) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_FULL;
              out_item_nxt.slot   = '0;
            end else if (in_item.position == '0 ||
                         CW'(in_item.position) > CW'(len_r) + CW'(1)) begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_POSITION;
              out_item_nxt.slot   = '0;
            end else begin
              rd_addr   = free_r;
              cur_nxt   = free_r;
              state_nxt = S_I_FREE;
            end
          end else if (len_r == '0 || head_r == '0) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.status = ST_MISSING;
            out_item_nxt.slot   = '0;
          end else begin
            rd_addr   = head_r;
            cur_nxt   = head_r;
            prev_nxt  = '0;
            cnt_nxt   = '0;
            state_nxt = S_L_CMP;
          end
        end
      end

      S_L_CMP: begin
        if (val_q == key_r) begin
          case (kind_r)
            K_DELETE: begin
              // unlink now, return the slot to the free chain next cycle
              if (prev_r == '0) begin
                head_nxt = link_eff;
              end else begin
                lnk_we    = 1'b1;
                lnk_waddr = prev_r;
                lnk_wdata = link_eff;
              end
              state_nxt = S_D_FREE;
            end
            K_REPLACE: begin
              val_we              = 1'b1;
              val_waddr           = cur_r;
              val_wdata           = nval_r;
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_OK;
              out_item_nxt.slot   = 3'(cur_r);
              state_nxt           = S_IDLE;
            end
            default: begin
              out_valid_nxt       = 1'b1;
              out_item_nxt.status = ST_OK;
              out_item_nxt.slot   = 3'(cur_r);
              state_nxt           = S_IDLE;
            end
          endcase
        end else if (cnt_r + 1'b1 >= len_r || link_eff == '0) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_MISSING;
          out_item_nxt.slot   = '0;
          state_nxt           = S_IDLE;
        end else begin
          // advance to the next node, its read issued this cycle
          rd_addr  = link_eff;
          prev_nxt = cur_r;
          cur_nxt  = link_eff;
          cnt_nxt  = cnt_r + 1'b1;
        end
      end

      S_D_FREE: begin
        lnk_we              = 1'b1;
        lnk_waddr           = cur_r;
        lnk_wdata           = free_r;
        free_nxt            = cur_r;
        len_nxt             = len_r - 1'b1;
        out_valid_nxt       = 1'b1;
        out_item_nxt.status = ST_OK;
        out_item_nxt.slot   = 3'(cur_r);
        state_nxt           = S_IDLE;
      end

      S_I_FREE: begin
        free_nxt  = link_eff;
        val_we    = 1'b1;
        val_waddr = cur_r;
        val_wdata = key_r;
        if (pos_r == 4'd1 || head_r == '0) begin
          lnk_we              = 1'b1;
          lnk_waddr           = cur_r;
          lnk_wdata           = head_r;
          head_nxt            = cur_r;
          len_nxt             = len_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_OK;
          out_item_nxt.slot   = 3'(cur_r);
          state_nxt           = S_IDLE;
        end else begin
          rd_addr   = head_r;
          prev_nxt  = head_r;
          hops_nxt  = pos_r - 4'd2;
          state_nxt = S_I_WALK;
        end
      end

      S_I_WALK: begin
        if (hops_r == '0) begin
          lnk_we    = 1'b1;
          lnk_waddr = cur_r;
          lnk_wdata = link_eff;
          state_nxt = S_I_LINK;
        end else if (link_eff == '0) begin
          // ran off the end: place at the head
          lnk_we              = 1'b1;
          lnk_waddr           = cur_r;
          lnk_wdata           = head_r;
          head_nxt            = cur_r;
          len_nxt             = len_r + 1'b1;
          out_valid_nxt       = 1'b1;
          out_item_nxt.status = ST_OK;
          out_item_nxt.slot   = 3'(cur_r);
          state_nxt           = S_IDLE;
        end else begin
          rd_addr  = link_eff;
          prev_nxt = link_eff;
          hops_nxt = hops_r - 1'b1;
        end
      end

      S_I_LINK: begin
        lnk_we              = 1'b1;
        lnk_waddr           = prev_r;
        lnk_wdata           = cur_r;
        len_nxt             = len_r + 1'b1;
        out_valid_nxt       = 1'b1;
        out_item_nxt.status = ST_OK;
        out_item_nxt.slot   = 3'(cur_r);
        state_nxt           = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    out_item_nxt.head = 3'(head_nxt);
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    cnt_r      <= cnt_nxt;
    hops_r     <= hops_nxt;
    kind_r     <= kind_nxt;
    pos_r      <= pos_nxt;
    key_r      <= key_nxt;
    nval_r     <= nval_nxt;
    rd_addr_r  <= rd_addr;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      free_r      <= SW'(1);
      len_r       <= '0;
      link_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      len_r       <= len_nxt;
      out_valid_r <= out_valid_nxt;
      if (lnk_we) begin
        link_vld_r[lnk_waddr] <= 1'b1;
      end
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_err_no_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> out_item.slot == '0)
    else $error("failed request reports a slot");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted item neither worked on nor answered");

  a_chains_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    !(free_r == head_r && head_r != '0))
    else $error("free chain and list share a head slot");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(len_r) < CW'(SLOTS))
    else $error("list length exceeds slot count");

endmodule
`default_nettype wire

[sv/clle_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module clle_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

[tb/cursor_linked_list_engine_tb.sv]
// Self-checking regression for the cursor linked list engine: directed and random requests.
`default_nettype none
module cursor_linked_list_engine_tb;
  import clle_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOTS = 8;

  logic      clk;
  logic      rst_n;
  logic      start;
  in_item_t  in_item;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  cursor_linked_list_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_item  (in_item),
    .busy     (busy),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Shadow of the slot store and free chain
  logic [15:0] node_val [NSLOTS];
  logic [2:0]  node_next [NSLOTS];
  logic [2:0]  free_top;
  logic [2:0]  list_top;
  int          list_len;

  out_item_t   predicted_replies [$];
  int          fail_count;
  int          requests_sent;
  int          status_seen [4];
  int          sender_idle_pct;

  logic [15:0] value_pool [6] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h0001, 16'h5A5A};

  function automatic void clear_list_shadow();
    for (int i = 0; i < NSLOTS; i++) begin
      node_val[i]  = '0;
      node_next[i] = (i + 1 < NSLOTS) ? 3'(i + 1) : 3'd0;
    end
    free_top = 3'd1;
    list_top = 3'd0;
    list_len = 0;
  endfunction

  function automatic out_item_t apply_list_request(input in_item_t req);
    out_item_t   res;
    logic [2:0]  s;
    logic [2:0]  p;
    logic [2:0]  cur;
    logic [2:0]  prev;
    logic        found;
    int          n;
    res.status = ST_OK;
    res.slot   = 3'd0;
    if (kind_t'(req.kind) == K_INSERT) begin
      s = free_top;
      if (s == 3'd0) begin
        res.status = ST_FULL;
      end else if (req.position == 4'd0 || int'(req.position) > list_len + 1) begin
        res.status = ST_POSITION;
      end else begin
        free_top    = node_next[s];
        node_val[s] = req.value;
        if (req.position == 4'd1) begin
          node_next[s] = list_top;
          list_top     = s;
        end else begin
          // walk to the node that will precede the new one
          p = list_top;
          for (n = 2; n < int'(req.position) && p != 3'd0; n++) p = node_next[p];
          if (p == 3'd0) begin
            node_next[s] = list_top;
            list_top     = s;
          end else begin
            node_next[s] = node_next[p];
            node_next[p] = s;
          end
        end
        list_len++;
        res.slot = s;
      end
    end else begin
      cur   = list_top;
      prev  = 3'd0;
      found = 1'b0;
      s     = 3'd0;
      for (n = 0; n < list_len && cur != 3'd0 && !found; n++) begin
        if (node_val[cur] == req.value) begin
          found = 1'b1;
          s     = cur;
        end else begin
          prev = cur;
          cur  = node_next[cur];
        end
      end
      if (!found) begin
        res.status = ST_MISSING;
      end else begin
        res.slot = s;
        if (kind_t'(req.kind) == K_DELETE) begin
          if (prev == 3'd0) list_top = node_next[s];
          else node_next[prev] = node_next[s];
          node_next[s] = free_top;
          free_top     = s;
          list_len--;
        end else if (kind_t'(req.kind) == K_REPLACE) begin
          node_val[s] = req.new_value;
        end
      end
    end
    res.head = list_top;
    return res;
  endfunction

  function automatic in_item_t mk_req(input kind_t k, input logic [3:0] pos,
                                      input logic [15:0] v, input logic [15:0] nv);
    in_item_t r;
    r.kind      = k;
    r.position  = pos;
    r.value     = v;
    r.new_value = nv;
    return r;
  endfunction

  // Mostly well-formed requests on a small value pool so lookups hit
  function automatic in_item_t make_random_request(input int insert_pct);
    in_item_t r;
    int       pick;
    pick = $urandom_range(99);
    if (pick < insert_pct) begin
      r.kind = K_INSERT;
    end else begin
      case ($urandom_range(2))
        0:       r.kind = K_DELETE;
        1:       r.kind = K_FIND;
        default: r.kind = K_REPLACE;
      endcase
    end
    if (kind_t'(r.kind) == K_INSERT && $urandom_range(99) < 85)
      r.position = 4'($urandom_range(list_len + 1, 1));
    else
      r.position = 4'($urandom_range(15));
    if ($urandom_range(99) < 80) r.value = value_pool[$urandom_range(5)];
    else r.value = 16'($urandom());
    if ($urandom_range(99) < 50) r.new_value = value_pool[$urandom_range(5)];
    else r.new_value = 16'($urandom());
    return r;
  endfunction

  task automatic send_req(input in_item_t req);
    out_item_t exp;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    exp = apply_list_request(req);
    predicted_replies.push_back(exp);
    status_seen[exp.status]++;
    requests_sent++;
  endtask

  // Hold off until every outstanding reply has come back
  task automatic drain_results();
    start <= 1'b0;
    while (predicted_replies.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic test_empty_list();
    send_req(mk_req(K_FIND, 4'd0, 16'h0005, 16'h0000));
    send_req(mk_req(K_DELETE, 4'd0, 16'h0005, 16'h0000));
    send_req(mk_req(K_REPLACE, 4'd0, 16'h0005, 16'h0006));
    send_req(mk_req(K_INSERT, 4'd0, 16'h0001, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd2, 16'h0001, 16'h0000));
  endtask

  task automatic test_fill_to_capacity();
    send_req(mk_req(K_INSERT, 4'd1, 16'h8000, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd2, 16'h7FFF, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd1, 16'h0000, 16'hFFFF));
    send_req(mk_req(K_INSERT, 4'd3, 16'hFFFF, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd5, 16'h0000, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd15, 16'h0007, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd3, 16'h7FFF, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd8, 16'h002A, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd7, 16'h002A, 16'h0000));
    // store is full now: full wins over a bad position
    send_req(mk_req(K_INSERT, 4'd0, 16'h0001, 16'h0000));
    send_req(mk_req(K_INSERT, 4'd1, 16'h0001, 16'h0000));
  endtask

  task automatic test_lookup_and_unlink();
    send_req(mk_req(K_FIND, 4'd0, 16'h0000, 16'h0000));
    send_req(mk_req(K_REPLACE, 4'd0, 16'h7FFF, 16'hFFFE));
    send_req(mk_req(K_FIND, 4'd0, 16'h7FFF, 16'h0000));
    send_req(mk_req(K_DELETE, 4'd0, 16'h0000, 16'h0000));
    send_req(mk_req(K_DELETE, 4'd0, 16'h002A, 16'h0000));
    send_req(mk_req(K_DELETE, 4'd0, 16'hFFFF, 16'h0000));
    send_req(mk_req(K_DELETE, 4'd0, 16'h1234, 16'h0000));
    send_req(mk_req(K_REPLACE, 4'd0, 16'h1234, 16'h4321));
    send_req(mk_req(K_INSERT, 4'd1, 16'h00FF, 16'h0000));
    send_req(mk_req(K_FIND, 4'd0, 16'hFFFE, 16'h0000));
  endtask

  task automatic test_random_traffic(input int count, input int idle_pct, input int insert_pct);
    sender_idle_pct = idle_pct;
    repeat (count) send_req(make_random_request(insert_pct));
  endtask

  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_valid) begin
      if (predicted_replies.size() == 0) begin
        $error("reply with none outstanding: status %0d slot %0d head %0d",
               out_item.status, out_item.slot, out_item.head);
        fail_count++;
      end else begin
        exp = predicted_replies.pop_front();
        if (out_item.status !== exp.status) begin
          $error("status mismatch: expected %0d, got %0d", exp.status, out_item.status);
          fail_count++;
        end
        if (out_item.slot !== exp.slot) begin
          $error("slot mismatch: expected %0d, got %0d", exp.slot, out_item.slot);
          fail_count++;
        end
        if (out_item.head !== exp.head) begin
          $error("head mismatch: expected %0d, got %0d", exp.head, out_item.head);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("cursor_linked_list_engine regression: fail");
    $finish;
  end

  initial begin
    int waited;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_item         = '0;
    fail_count      = 0;
    requests_sent   = 0;
    sender_idle_pct = 24;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_list_shadow();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_list();
    test_fill_to_capacity();
    drain_results();
    test_lookup_and_unlink();
    drain_results();
    test_random_traffic(300, 24, 45);
    drain_results();
    test_random_traffic(300, 75, 35);
    test_random_traffic(300, 0, 40);

    start  <= 1'b0;
    waited = 0;
    while (predicted_replies.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      $error("%0d replies never arrived", predicted_replies.size());
      fail_count++;
    end

    $display("covered %0d requests over empty, partial and full lists", requests_sent);
    $display("replies: %0d ok, %0d not found, %0d store full, %0d bad position",
             status_seen[ST_OK], status_seen[ST_MISSING], status_seen[ST_FULL],
             status_seen[ST_POSITION]);
    if (fail_count == 0) begin
      $display("cursor_linked_list_engine regression: pass");
    end else begin
      $display("cursor_linked_list_engine regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
